### sv/imu_frame_deframer_unit_assert.svh
// assertion helpers for the imu frame deframer
`ifndef IMU_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define IFD_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("ifd check failed");
`define IFD_ASSERT_ALWAYS(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) \
    else $error("ifd check failed");
`else
`define IFD_ASSERT(lbl, clk_s, rst_s, prop)
`define IFD_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif

`endif

### sv/ifd_pkg.sv
`default_nettype none
package ifd_pkg;

    localparam int BUF_DEPTH   = 64;
    localparam int AW          = $clog2(BUF_DEPTH);
    localparam int LW          = $clog2(BUF_DEPTH + 1);
    localparam int ACC_BYTES   = 6;
    localparam int MAG_BYTES   = 6;
    localparam int GYRO_BYTES  = 6;
    localparam int EULER_BYTES = 6;
    localparam int QUAT_BYTES  = 8;
    localparam int MAX_RESULTS = 16;
    localparam int FRAME_EXTRA = 6;

    localparam logic [7:0] SYNC_BYTE = 8'h5A;

    localparam logic [2:0] KIND_ACC    = 3'd0;
    localparam logic [2:0] KIND_GYRO   = 3'd1;
    localparam logic [2:0] KIND_QUAT   = 3'd2;
    localparam logic [2:0] KIND_CALIB  = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    localparam logic [2:0] BLK_ACC   = 3'd0;
    localparam logic [2:0] BLK_MAG   = 3'd1;
    localparam logic [2:0] BLK_GYRO  = 3'd2;
    localparam logic [2:0] BLK_EULER = 3'd3;
    localparam logic [2:0] BLK_QUAT  = 3'd4;
    localparam logic [2:0] BLK_END   = 3'd5;

    function automatic logic [LW-1:0] payload_size(input logic [7:0] m);
        logic [LW-1:0] n;
        n = '0;
        if (m[0]) n = n + LW'(ACC_BYTES);
        if (m[1]) n = n + LW'(MAG_BYTES);
        if (m[2]) n = n + LW'(GYRO_BYTES);
        if (m[3]) n = n + LW'(EULER_BYTES);
        if (m[4]) n = n + LW'(QUAT_BYTES);
        return n;
    endfunction

    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [LW-1:0] lidx);
        logic [LW:0] s;
        s = {{(LW + 1 - AW){1'b0}}, base} + {1'b0, lidx};
        if (s >= (LW + 1)'(BUF_DEPTH)) s = s - (LW + 1)'(BUF_DEPTH);
        return s[AW-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/imu_frame_deframer_unit.sv
// Byte-stream deframer for 5A 5A | mask | length | payload | calib | sum frames. Each received
// byte is stored in a 64-byte circular frame store, then a sequencer walks the store through
// its single read port: it tries each start position in the header hunt, does the length
// check and reads the mask, sums each frame byte for the checksum, visits each block slot to
// pick the blocks, loads each accel, gyro or quaternion byte, builds and emits each such
// record and then the calibration record. An empty-mask reject and a checksum reject each
// emit a reject record and are followed by a rescan. The input is stalled while a byte is
// being worked on, and longer while the output is stalled. Records leave through an output
// register; the last record a byte causes has last_record set.
`default_nettype none
`include "imu_frame_deframer_unit_assert.svh"
module imu_frame_deframer_unit
    import ifd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               quat_order,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              record_kind,
    output logic signed [15:0]      value0,
    output logic signed [15:0]      value1,
    output logic signed [15:0]      value2,
    output logic signed [15:0]      value3,
    output logic [31:0]             good_frames,
    output logic [31:0]             bad_frames,
    output logic                    last_record
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_TOP, ST_H0, ST_H1, ST_HDR, ST_MASK, ST_SUM,
        ST_PSEL, ST_PRD, ST_PREC, ST_EMIT, ST_FIN
    } state_t;

    state_t state_reg, ret_reg;

    logic [AW-1:0] base_reg;
    logic [LW-1:0] fill_reg, rp_reg;
    logic [LW-1:0] flen_reg, idx_reg, pos_reg;
    logic [7:0]    mask_reg, sum_reg, calib_reg, b0_reg;
    logic [2:0]    blk_reg, bidx_reg;
    logic [4:0]    cnt_reg;
    logic [31:0]   good_reg, bad_reg;
    logic          quat_order_reg;
    logic [7:0]    pl_reg [8];

    logic [2:0]    rec_kind_reg;
    logic [15:0]   rec_v_reg [4];

    logic          pend_valid_reg;
    logic [2:0]    pend_kind_reg;
    logic [15:0]   pend_v_reg [4];
    logic [31:0]   pend_good_reg, pend_bad_reg;

    logic          out_valid_reg, out_last_reg;
    logic [2:0]    out_kind_reg;
    logic [15:0]   out_v_reg [4];
    logic [31:0]   out_good_reg, out_bad_reg;

    logic          accept, out_free, load_out;
    logic [AW-1:0] base1, base2, wr_addr, rd_addr;
    logic [LW-1:0] fill1, fill2, avail, rd_off, psize;
    logic [7:0]    rd_data;
    logic [LW-1:0] blk_len;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_out  = pend_valid_reg && out_free &&
                       (state_reg == ST_EMIT || state_reg == ST_FIN);
    assign avail     = fill_reg - rp_reg;
    assign psize     = payload_size(rd_data);
    assign blk_len   = (blk_reg == BLK_QUAT) ? LW'(QUAT_BYTES) : LW'(ACC_BYTES);

    // make room when the store is full
    always_comb
    begin
        base1 = base_reg;
        fill1 = fill_reg;
        base2 = base_reg;
        fill2 = fill_reg;
        if (fill_reg >= LW'(BUF_DEPTH))
        begin
            base1 = wrap_addr(base_reg, rp_reg);
            fill1 = fill_reg - rp_reg;
            base2 = base1;
            fill2 = fill1;
            if (fill1 >= LW'(BUF_DEPTH))
            begin
                base2 = wrap_addr(base1, LW'(1));
                fill2 = LW'(BUF_DEPTH - 1);
            end
        end
        wr_addr = wrap_addr(base2, fill2);
    end

    always_comb
    begin
        case (state_reg)
            ST_H0:   rd_off = LW'(1);
            ST_HDR:  rd_off = LW'(2);
            ST_SUM:  rd_off = idx_reg + LW'(1);
            ST_PSEL: rd_off = pos_reg;
            ST_PRD:  rd_off = pos_reg + LW'(bidx_reg) + LW'(1);
            default: rd_off = '0;
        endcase
        rd_addr = wrap_addr(base_reg, rp_reg + rd_off);
    end

    ifd_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_order_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quat_order_reg <= quat_order;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_TOP;
            base_reg       <= '0;
            fill_reg       <= '0;
            rp_reg         <= '0;
            cnt_reg        <= '0;
            good_reg       <= '0;
            bad_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        base_reg  <= base2;
                        fill_reg  <= fill2 + LW'(1);
                        if (fill_reg >= LW'(BUF_DEPTH))
                        begin
                            rp_reg <= '0;
                        end
                        cnt_reg   <= '0;
                        state_reg <= ST_TOP;
                    end
                end
                ST_TOP:
                begin
                    if (cnt_reg > 5'(MAX_RESULTS - 4) || avail < LW'(2))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_H0;
                    end
                end
                ST_H0:
                begin
                    b0_reg    <= rd_data;
                    state_reg <= ST_H1;
                end
                ST_H1:
                begin
                    if (b0_reg == SYNC_BYTE && rd_data == SYNC_BYTE)
                    begin
                        state_reg <= ST_HDR;
                    end
                    else
                    begin
                        rp_reg    <= rp_reg + LW'(1);
                        state_reg <= ST_TOP;
                    end
                end
                ST_HDR:
                begin
                    state_reg <= (avail < LW'(4)) ? ST_FIN : ST_MASK;
                end
                ST_MASK:
                begin
                    mask_reg <= rd_data;
                    flen_reg <= psize + LW'(FRAME_EXTRA);
                    idx_reg  <= '0;
                    sum_reg  <= '0;
                    if (psize == '0)
                    begin
                        bad_reg      <= bad_reg + 32'd1;
                        rp_reg       <= rp_reg + LW'(2);
                        rec_kind_reg <= KIND_REJECT;
                        rec_v_reg    <= '{default: 16'd0};
                        ret_reg      <= ST_TOP;
                        state_reg    <= ST_EMIT;
                    end
                    else if (avail < psize + LW'(FRAME_EXTRA))
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    if (idx_reg == flen_reg - LW'(1))
                    begin
                        if (sum_reg != rd_data)
                        begin
                            bad_reg      <= bad_reg + 32'd1;
                            rp_reg       <= rp_reg + LW'(2);
                            rec_kind_reg <= KIND_REJECT;
                            rec_v_reg    <= '{default: 16'd0};
                            ret_reg      <= ST_TOP;
                            state_reg    <= ST_EMIT;
                        end
                        else
                        begin
                            good_reg  <= good_reg + 32'd1;
                            blk_reg   <= BLK_ACC;
                            pos_reg   <= LW'(4);
                            state_reg <= ST_PSEL;
                        end
                    end
                    else
                    begin
                        sum_reg <= sum_reg + rd_data;
                        if (idx_reg == flen_reg - LW'(2))
                        begin
                            calib_reg <= rd_data;
                        end
                        idx_reg <= idx_reg + LW'(1);
                    end
                end
                ST_PSEL:
                begin
                    if (blk_reg == BLK_END)
                    begin
                        rp_reg       <= rp_reg + flen_reg;
                        rec_kind_reg <= KIND_CALIB;
                        rec_v_reg[0] <= {14'd0, calib_reg[7:6]};
                        rec_v_reg[1] <= {14'd0, calib_reg[5:4]};
                        rec_v_reg[2] <= {14'd0, calib_reg[3:2]};
                        rec_v_reg[3] <= {14'd0, calib_reg[1:0]};
                        ret_reg      <= ST_TOP;
                        state_reg    <= ST_EMIT;
                    end
                    else if (!mask_reg[blk_reg])
                    begin
                        blk_reg <= blk_reg + 3'd1;
                    end
                    else if (blk_reg == BLK_MAG || blk_reg == BLK_EULER)
                    begin
                        pos_reg <= pos_reg + LW'(MAG_BYTES);
                        blk_reg <= blk_reg + 3'd1;
                    end
                    else
                    begin
                        bidx_reg  <= '0;
                        state_reg <= ST_PRD;
                    end
                end
                ST_PRD:
                begin
                    pl_reg[bidx_reg] <= rd_data;
                    if (LW'(bidx_reg) == blk_len - LW'(1))
                    begin
                        state_reg <= ST_PREC;
                    end
                    else
                    begin
                        bidx_reg <= bidx_reg + 3'd1;
                    end
                end
                ST_PREC:
                begin
                    pos_reg <= pos_reg + blk_len;
                    blk_reg <= blk_reg + 3'd1;
                    ret_reg <= ST_PSEL;
                    state_reg <= ST_EMIT;
                    case (blk_reg)
                        BLK_QUAT:
                        begin
                            rec_kind_reg <= KIND_QUAT;
                            if (quat_order_reg)
                            begin
                                rec_v_reg[0] <= {pl_reg[0], pl_reg[1]};
                                rec_v_reg[1] <= {pl_reg[2], pl_reg[3]};
                                rec_v_reg[2] <= {pl_reg[4], pl_reg[5]};
                                rec_v_reg[3] <= {pl_reg[6], pl_reg[7]};
                            end
                            else
                            begin
                                rec_v_reg[0] <= {pl_reg[2], pl_reg[3]};
                                rec_v_reg[1] <= {pl_reg[4], pl_reg[5]};
                                rec_v_reg[2] <= {pl_reg[6], pl_reg[7]};
                                rec_v_reg[3] <= {pl_reg[0], pl_reg[1]};
                            end
                        end
                        default:
                        begin
                            rec_kind_reg <= (blk_reg == BLK_GYRO) ? KIND_GYRO : KIND_ACC;
                            rec_v_reg[0] <= {pl_reg[0], pl_reg[1]};
                            rec_v_reg[1] <= {pl_reg[2], pl_reg[3]};
                            rec_v_reg[2] <= {pl_reg[4], pl_reg[5]};
                            rec_v_reg[3] <= 16'd0;
                        end
                    endcase
                end
                ST_EMIT:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_last_reg  <= 1'b0;
                            out_kind_reg  <= pend_kind_reg;
                            out_v_reg     <= pend_v_reg;
                            out_good_reg  <= pend_good_reg;
                            out_bad_reg   <= pend_bad_reg;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_kind_reg  <= rec_kind_reg;
                        pend_v_reg     <= rec_v_reg;
                        pend_good_reg  <= good_reg;
                        pend_bad_reg   <= bad_reg;
                        cnt_reg        <= cnt_reg + 5'd1;
                        state_reg      <= ret_reg;
                    end
                end
                ST_FIN:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_last_reg  <= 1'b1;
                            out_kind_reg  <= pend_kind_reg;
                            out_v_reg     <= pend_v_reg;
                            out_good_reg  <= pend_good_reg;
                            out_bad_reg   <= pend_bad_reg;
                        end
                        pend_valid_reg <= 1'b0;
                        if (rp_reg >= fill_reg)
                        begin
                            rp_reg   <= '0;
                            fill_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign record_kind = out_kind_reg;
    assign value0      = $signed(out_v_reg[0]);
    assign value1      = $signed(out_v_reg[1]);
    assign value2      = $signed(out_v_reg[2]);
    assign value3      = $signed(out_v_reg[3]);
    assign good_frames = out_good_reg;
    assign bad_frames  = out_bad_reg;
    assign last_record = out_last_reg;

    `IFD_ASSERT(a_rp_in_store, clk, rst_n, rp_reg <= fill_reg)
    `IFD_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= LW'(BUF_DEPTH))
    `IFD_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= 5'(MAX_RESULTS))
    `IFD_ASSERT(a_accept_busy, clk, rst_n, accept |=> state_reg != ST_IDLE)
    `IFD_ASSERT(a_idle_no_pend, clk, rst_n, state_reg == ST_IDLE |-> !pend_valid_reg)

endmodule
`default_nettype wire

### sv/ifd_ram.sv
`default_nettype none
module ifd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire
